// ===== sv/bhpq_pkg.sv =====
`default_nettype none
package bhpq_pkg;

    localparam int CAPACITY_DEF     = 64;
    localparam int KEY_BITS_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 8;

    // action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_PEEK   = 2'd2;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    // microprogram entry points
    localparam upc_t S_IDLE    = 5'd0;
    localparam upc_t S_DISP    = 5'd1;
    localparam upc_t S_INS     = 5'd5;
    localparam upc_t S_UP      = 5'd7;
    localparam upc_t S_UPDONE  = 5'd10;
    localparam upc_t S_POP     = 5'd11;
    localparam upc_t S_DN      = 5'd15;
    localparam upc_t S_DNCMP   = 5'd19;
    localparam upc_t S_DNDONE  = 5'd21;
    localparam upc_t S_PEEK    = 5'd22;
    localparam upc_t S_EMIT    = 5'd25;

    typedef enum logic [1:0] {
        SK_RUN,
        SK_WAIT_IN,
        SK_EMIT
    } step_kind_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_ACT_INS,
        C_ACT_POP,
        C_ACT_PEEK,
        C_FULL,
        C_EMPTY,
        C_POS0,
        C_NO_LC,
        C_NO_RC,
        C_CUR_NOT_ABOVE,
        C_RC_NOT_BETTER,
        C_BEST_NOT_ABOVE
    } cond_t;

    typedef enum logic [2:0] {
        RS_NONE,
        RS_PARENT,
        RS_ROOT,
        RS_LAST,
        RS_LC,
        RS_RC
    } rsel_t;

    typedef enum logic [1:0] {
        WS_NONE,
        WS_CUR,
        WS_RD,
        WS_BEST
    } wsel_t;

    typedef enum logic [2:0] {
        PS_HOLD,
        PS_CNT,
        PS_ZERO,
        PS_PARENT,
        PS_BEST
    } psel_t;

    typedef enum logic [1:0] {
        CO_HOLD,
        CO_INC,
        CO_DEC
    } cop_t;

    typedef enum logic [1:0] {
        BS_HOLD,
        BS_LC,
        BS_RC
    } bsel_t;

    typedef struct packed {
        step_kind_t kind;
        cond_t      cond;
        upc_t       target;
        rsel_t      rsel;
        wsel_t      wsel;
        psel_t      psel;
        cop_t       cop;
        bsel_t      bsel;
        logic       ld_cur;
        logic       ld_res;
        logic       set_ok;
    } ucw_t;

    typedef struct packed {
        logic act_ins;
        logic act_pop;
        logic act_peek;
        logic full;
        logic empty;
        logic pos0;
        logic no_lc;
        logic no_rc;
        logic cur_not_above;
        logic rc_not_better;
        logic best_not_above;
    } flags_t;

    localparam ucw_t UCW_NOP = '{
        kind:   SK_RUN,
        cond:   C_NEVER,
        target: S_IDLE,
        rsel:   RS_NONE,
        wsel:   WS_NONE,
        psel:   PS_HOLD,
        cop:    CO_HOLD,
        bsel:   BS_HOLD,
        ld_cur: 1'b0,
        ld_res: 1'b0,
        set_ok: 1'b0
    };

    function automatic ucw_t ucode_rom(input upc_t a);
        ucw_t w;
        begin
            w = UCW_NOP;
            case (a)
                S_IDLE:
                begin
                    w.kind = SK_WAIT_IN;
                end
                // dispatch on action
                5'd1:
                begin
                    w.cond = C_ACT_INS; w.target = S_INS;
                end
                5'd2:
                begin
                    w.cond = C_ACT_POP; w.target = S_POP;
                end
                5'd3:
                begin
                    w.cond = C_ACT_PEEK; w.target = S_PEEK;
                end
                5'd4:
                begin
                    w.cond = C_ALWAYS; w.target = S_EMIT;
                end
                // insert
                S_INS:
                begin
                    w.cond = C_FULL; w.target = S_EMIT;
                end
                5'd6:
                begin
                    w.psel = PS_CNT; w.cop = CO_INC; w.set_ok = 1'b1;
                end
                S_UP:
                begin
                    w.cond = C_POS0; w.target = S_UPDONE; w.rsel = RS_PARENT;
                end
                5'd8:
                begin
                    w.cond = C_CUR_NOT_ABOVE; w.target = S_UPDONE;
                end
                5'd9:
                begin
                    w.wsel = WS_RD; w.psel = PS_PARENT;
                    w.cond = C_ALWAYS; w.target = S_UP;
                end
                S_UPDONE:
                begin
                    w.wsel = WS_CUR; w.cond = C_ALWAYS; w.target = S_EMIT;
                end
                // pop
                S_POP:
                begin
                    w.cond = C_EMPTY; w.target = S_EMIT;
                end
                5'd12:
                begin
                    w.rsel = RS_ROOT;
                end
                5'd13:
                begin
                    w.ld_res = 1'b1; w.set_ok = 1'b1; w.rsel = RS_LAST; w.cop = CO_DEC;
                end
                5'd14:
                begin
                    w.ld_cur = 1'b1; w.psel = PS_ZERO;
                    w.cond = C_EMPTY; w.target = S_EMIT;
                end
                S_DN:
                begin
                    w.cond = C_NO_LC; w.target = S_DNDONE; w.rsel = RS_LC;
                end
                5'd16:
                begin
                    w.bsel = BS_LC; w.rsel = RS_RC;
                    w.cond = C_NO_RC; w.target = S_DNCMP;
                end
                5'd17:
                begin
                    w.cond = C_RC_NOT_BETTER; w.target = S_DNCMP;
                end
                5'd18:
                begin
                    w.bsel = BS_RC;
                end
                S_DNCMP:
                begin
                    w.cond = C_BEST_NOT_ABOVE; w.target = S_DNDONE;
                end
                5'd20:
                begin
                    w.wsel = WS_BEST; w.psel = PS_BEST;
                    w.cond = C_ALWAYS; w.target = S_DN;
                end
                S_DNDONE:
                begin
                    w.wsel = WS_CUR; w.cond = C_ALWAYS; w.target = S_EMIT;
                end
                // peek
                S_PEEK:
                begin
                    w.cond = C_EMPTY; w.target = S_EMIT;
                end
                5'd23:
                begin
                    w.rsel = RS_ROOT;
                end
                5'd24:
                begin
                    w.ld_res = 1'b1; w.set_ok = 1'b1;
                    w.cond = C_ALWAYS; w.target = S_EMIT;
                end
                S_EMIT:
                begin
                    w.kind = SK_EMIT;
                end
                default:
                begin
                    w.cond = C_ALWAYS; w.target = S_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/binary_heap_priority_queue.sv =====
`default_nettype none
// channel   | dir | handshake        | tdata (low bit up)             | tuser
// s_*       | in  | s_tvalid/tready  | key, payload                   | action
// m_*       | out | m_tvalid/tready  | key_out, payload_out, count_out| ok
// cfg_wr_*  | in  | cfg_wr_en        | cfg_wr_data = max_order        | -
//
// one transaction at a time; a microprogram step per cycle over a heap ram with one read
// and one write port, but the emit step holds while a stalled result waits for m_tready;
// peek reads the root; insert climbs and pop descends at most log2 of capacity levels;
// refused actions (full insert, empty pop or peek, unused action) go straight to emit
// reset empties the heap and selects min order; no clearing pass is needed
// a stalled m_tready holds the finished result; the next transaction runs and then
// waits at its emit step with s_tready low
module binary_heap_priority_queue #(
    parameter int CAPACITY     = bhpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS     = bhpq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = bhpq_pkg::PAYLOAD_BITS_DEF,
    localparam int AW    = $clog2(CAPACITY),
    localparam int CW    = $clog2(CAPACITY + 1),
    localparam int EW    = KEY_BITS + PAYLOAD_BITS,
    localparam int IN_W  = ((EW + 7) / 8) * 8,
    localparam int OUT_W = ((EW + CW + 7) / 8) * 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_wr_data,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // key, payload
    input  wire logic [1:0]       s_tuser,   // action
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [OUT_W-1:0] m_tdata,   // key_out, payload_out, count_out
    output logic      [0:0]       m_tuser    // ok
);

    bhpq_pkg::ucw_t   ctrl;
    bhpq_pkg::flags_t flags;
    logic             idle;
    logic             accept;
    logic             out_free;
    logic             emit;

    logic                    max_order_reg;
    logic [CW-1:0]           cnt_reg;
    logic [CW-1:0]           cnt_next;
    logic [AW-1:0]           pos_reg;
    logic [AW-1:0]           pos_next;
    logic [1:0]              act_reg;
    logic [KEY_BITS-1:0]     cur_key_reg;
    logic [PAYLOAD_BITS-1:0] cur_pay_reg;
    logic [KEY_BITS-1:0]     best_key_reg;
    logic [PAYLOAD_BITS-1:0] best_pay_reg;
    logic [AW-1:0]           best_idx_reg;
    logic [KEY_BITS-1:0]     res_key_reg;
    logic [PAYLOAD_BITS-1:0] res_pay_reg;
    logic                    ok_reg;
    logic                    m_tvalid_reg;
    logic [KEY_BITS-1:0]     out_key_reg;
    logic [PAYLOAD_BITS-1:0] out_pay_reg;
    logic [CW-1:0]           out_cnt_reg;
    logic                    out_ok_reg;

    logic [AW-1:0]           parent_idx;
    logic [AW-1:0]           last_idx;
    logic [AW+1:0]           lc_w;
    logic [AW+1:0]           rc_w;
    logic [AW+1:0]           cnt_w;

    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [EW-1:0]           rd_data;
    logic [KEY_BITS-1:0]     rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic                    wr_en;
    logic [EW-1:0]           wr_data;

    // true when key a belongs above key b under the current order
    function automatic logic above(input logic [KEY_BITS-1:0] a,
                                   input logic [KEY_BITS-1:0] b,
                                   input logic mo);
        return mo ? (a > b) : (a < b);
    endfunction

    assign s_tready = idle;
    assign accept   = s_tvalid & idle;
    assign out_free = ~m_tvalid_reg | m_tready;
    assign emit     = (ctrl.kind == bhpq_pkg::SK_EMIT) & out_free;

    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign last_idx   = AW'(cnt_reg - CW'(1));
    assign lc_w       = {1'b0, pos_reg, 1'b1};
    assign rc_w       = lc_w + (AW + 2)'(1);
    assign cnt_w      = (AW + 2)'(cnt_reg);

    assign rd_key = rd_data[KEY_BITS-1:0];
    assign rd_pay = rd_data[EW-1:KEY_BITS];

    always_comb
    begin
        flags.act_ins        = (act_reg == bhpq_pkg::ACT_INSERT);
        flags.act_pop        = (act_reg == bhpq_pkg::ACT_POP);
        flags.act_peek       = (act_reg == bhpq_pkg::ACT_PEEK);
        flags.full           = (cnt_reg == CW'(CAPACITY));
        flags.empty          = (cnt_reg == '0);
        flags.pos0           = (pos_reg == '0);
        flags.no_lc          = (lc_w >= cnt_w);
        flags.no_rc          = (rc_w >= cnt_w);
        flags.cur_not_above  = ~above(cur_key_reg, rd_key, max_order_reg);
        flags.rc_not_better  = ~above(rd_key, best_key_reg, max_order_reg);
        flags.best_not_above = ~above(best_key_reg, cur_key_reg, max_order_reg);
    end

    // ram read port
    always_comb
    begin
        rd_en = 1'b1;
        case (ctrl.rsel)
            bhpq_pkg::RS_PARENT: rd_addr = parent_idx;
            bhpq_pkg::RS_ROOT:   rd_addr = '0;
            bhpq_pkg::RS_LAST:   rd_addr = last_idx;
            bhpq_pkg::RS_LC:     rd_addr = lc_w[AW-1:0];
            bhpq_pkg::RS_RC:     rd_addr = rc_w[AW-1:0];
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    // ram write port, always at the hole position
    always_comb
    begin
        wr_en = 1'b1;
        case (ctrl.wsel)
            bhpq_pkg::WS_CUR:  wr_data = {cur_pay_reg, cur_key_reg};
            bhpq_pkg::WS_RD:   wr_data = rd_data;
            bhpq_pkg::WS_BEST: wr_data = {best_pay_reg, best_key_reg};
            default:
            begin
                wr_en   = 1'b0;
                wr_data = rd_data;
            end
        endcase
    end

    always_comb
    begin
        case (ctrl.psel)
            bhpq_pkg::PS_CNT:    pos_next = AW'(cnt_reg);
            bhpq_pkg::PS_ZERO:   pos_next = '0;
            bhpq_pkg::PS_PARENT: pos_next = parent_idx;
            bhpq_pkg::PS_BEST:   pos_next = best_idx_reg;
            default:             pos_next = pos_reg;
        endcase
        case (ctrl.cop)
            bhpq_pkg::CO_INC: cnt_next = cnt_reg + CW'(1);
            bhpq_pkg::CO_DEC: cnt_next = cnt_reg - CW'(1);
            default:          cnt_next = cnt_reg;
        endcase
    end

    bhpq_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .flags    (flags),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .ctrl     (ctrl),
        .idle     (idle)
    );

    bhpq_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pos_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_order_reg <= 1'b0;
            cnt_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_order_reg <= cfg_wr_data;
            end
            cnt_reg <= cnt_next;
            if (emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (accept)
        begin
            act_reg     <= s_tuser;
            cur_key_reg <= s_tdata[KEY_BITS-1:0];
            cur_pay_reg <= s_tdata[EW-1:KEY_BITS];
            res_key_reg <= '0;
            res_pay_reg <= '0;
            ok_reg      <= 1'b0;
        end
        else
        begin
            if (ctrl.ld_cur)
            begin
                cur_key_reg <= rd_key;
                cur_pay_reg <= rd_pay;
            end
            if (ctrl.ld_res)
            begin
                res_key_reg <= rd_key;
                res_pay_reg <= rd_pay;
            end
            if (ctrl.set_ok)
            begin
                ok_reg <= 1'b1;
            end
        end
        case (ctrl.bsel)
            bhpq_pkg::BS_LC:
            begin
                best_key_reg <= rd_key;
                best_pay_reg <= rd_pay;
                best_idx_reg <= lc_w[AW-1:0];
            end
            bhpq_pkg::BS_RC:
            begin
                best_key_reg <= rd_key;
                best_pay_reg <= rd_pay;
                best_idx_reg <= rc_w[AW-1:0];
            end
            default:
            begin
                best_idx_reg <= best_idx_reg;
            end
        endcase
        if (emit)
        begin
            out_key_reg <= res_key_reg;
            out_pay_reg <= res_pay_reg;
            out_cnt_reg <= cnt_reg;
            out_ok_reg  <= ok_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({out_cnt_reg, out_pay_reg, out_key_reg});
    assign m_tuser  = out_ok_reg;

endmodule
`default_nettype wire

// ===== sv/bhpq_mem.sv =====
`default_nettype none
module bhpq_mem #(
    parameter int DEPTH = bhpq_pkg::CAPACITY_DEF,
    parameter int WIDTH = bhpq_pkg::KEY_BITS_DEF + bhpq_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/bhpq_seq.sv =====
`default_nettype none
module bhpq_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bhpq_pkg::flags_t flags,
    input  wire logic             in_valid,
    input  wire logic             out_free,
    output bhpq_pkg::ucw_t        ctrl,
    output logic                  idle
);

    bhpq_pkg::upc_t upc_reg;
    bhpq_pkg::upc_t upc_next;
    logic           cond_hit;

    assign ctrl = bhpq_pkg::ucode_rom(upc_reg);
    assign idle = (ctrl.kind == bhpq_pkg::SK_WAIT_IN);

    always_comb
    begin
        case (ctrl.cond)
            bhpq_pkg::C_NEVER:          cond_hit = 1'b0;
            bhpq_pkg::C_ALWAYS:         cond_hit = 1'b1;
            bhpq_pkg::C_ACT_INS:        cond_hit = flags.act_ins;
            bhpq_pkg::C_ACT_POP:        cond_hit = flags.act_pop;
            bhpq_pkg::C_ACT_PEEK:       cond_hit = flags.act_peek;
            bhpq_pkg::C_FULL:           cond_hit = flags.full;
            bhpq_pkg::C_EMPTY:          cond_hit = flags.empty;
            bhpq_pkg::C_POS0:           cond_hit = flags.pos0;
            bhpq_pkg::C_NO_LC:          cond_hit = flags.no_lc;
            bhpq_pkg::C_NO_RC:          cond_hit = flags.no_rc;
            bhpq_pkg::C_CUR_NOT_ABOVE:  cond_hit = flags.cur_not_above;
            bhpq_pkg::C_RC_NOT_BETTER:  cond_hit = flags.rc_not_better;
            bhpq_pkg::C_BEST_NOT_ABOVE: cond_hit = flags.best_not_above;
            default:                    cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        case (ctrl.kind)
            bhpq_pkg::SK_WAIT_IN:
            begin
                upc_next = in_valid ? bhpq_pkg::S_DISP : upc_reg;
            end
            bhpq_pkg::SK_EMIT:
            begin
                // hold here until the output register can take the result
                upc_next = out_free ? bhpq_pkg::S_IDLE : upc_reg;
            end
            default:
            begin
                upc_next = cond_hit ? ctrl.target : upc_reg + bhpq_pkg::UPC_W'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= bhpq_pkg::S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule
`default_nettype wire

// ===== verif/tb_binary_heap_priority_queue.sv =====
`timescale 1ns / 1ps

module tb_binary_heap_priority_queue;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int HEAP_SLOTS = bhpq_pkg::CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS = 135;

    typedef struct packed {
        logic        ok;
        logic [15:0] key;
        logic [7:0]  payload;
        logic [6:0]  count;
    } heap_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // key, payload
    logic [1:0]  s_tuser = '0;   // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // key_out, payload_out, count_out
    logic [0:0]  m_tuser;        // ok

    binary_heap_priority_queue uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow heap used for prediction
    logic [15:0]  shadow_key [HEAP_SLOTS];
    logic [7:0]   shadow_payload [HEAP_SLOTS];
    int           shadow_count = 0;
    bit           largest_first = 1'b0;

    heap_result_t expected_results [$];

    int mismatches = 0;
    int results_checked = 0;
    int inserts_done = 0;
    int pops_done = 0;
    int peeks_done = 0;
    int refused = 0;
    int full_refusals = 0;
    int order_writes = 0;
    int deepest_count = 0;

    bit sender_gaps = 1'b1;
    int burst_left = 0;

    function automatic bit ranks_above(input logic [15:0] a, input logic [15:0] b);
        return largest_first ? (a > b) : (a < b);
    endfunction

    function automatic void swap_entries(input int i, input int j);
        logic [15:0] k;
        logic [7:0]  p;
        k = shadow_key[i];
        p = shadow_payload[i];
        shadow_key[i] = shadow_key[j];
        shadow_payload[i] = shadow_payload[j];
        shadow_key[j] = k;
        shadow_payload[j] = p;
    endfunction

    function automatic heap_result_t predict_transaction(input logic [1:0] act,
                                                         input logic [15:0] key,
                                                         input logic [7:0] payload);
        heap_result_t r;
        int pos;
        int up;
        int best;
        int lc;
        int rc;
        bit done;
        r = '0;
        case (act)
            bhpq_pkg::ACT_INSERT:
            begin
                if (shadow_count < HEAP_SLOTS)
                begin
                    shadow_key[shadow_count] = key;
                    shadow_payload[shadow_count] = payload;
                    pos = shadow_count;
                    shadow_count++;
                    done = 1'b0;
                    while (pos > 0 && !done)
                    begin
                        up = (pos - 1) / 2;
                        if (ranks_above(shadow_key[pos], shadow_key[up]))
                        begin
                            swap_entries(pos, up);
                            pos = up;
                        end
                        else
                            done = 1'b1;
                    end
                    r.ok = 1'b1;
                    inserts_done++;
                end
                else
                    full_refusals++;
            end
            bhpq_pkg::ACT_POP:
            begin
                if (shadow_count > 0)
                begin
                    r.ok = 1'b1;
                    r.key = shadow_key[0];
                    r.payload = shadow_payload[0];
                    shadow_key[0] = shadow_key[shadow_count - 1];
                    shadow_payload[0] = shadow_payload[shadow_count - 1];
                    shadow_count--;
                    pos = 0;
                    done = 1'b0;
                    while (!done)
                    begin
                        best = pos;
                        lc = 2 * pos + 1;
                        rc = 2 * pos + 2;
                        if (lc < shadow_count && ranks_above(shadow_key[lc], shadow_key[best]))
                            best = lc;
                        if (rc < shadow_count && ranks_above(shadow_key[rc], shadow_key[best]))
                            best = rc;
                        if (best == pos)
                            done = 1'b1;
                        else
                        begin
                            swap_entries(pos, best);
                            pos = best;
                        end
                    end
                    pops_done++;
                end
            end
            bhpq_pkg::ACT_PEEK:
            begin
                if (shadow_count > 0)
                begin
                    r.ok = 1'b1;
                    r.key = shadow_key[0];
                    r.payload = shadow_payload[0];
                    peeks_done++;
                end
            end
            default:
            begin
            end
        endcase
        if (!r.ok)
            refused++;
        if (shadow_count > deepest_count)
            deepest_count = shadow_count;
        r.count = 7'(shadow_count);
        return r;
    endfunction

    // one input transaction, with bursts and random gaps on the sender side
    task automatic send_item(input logic [1:0] act, input logic [15:0] key,
                             input logic [7:0] payload);
        int gap;
        if (sender_gaps && burst_left == 0)
        begin
            gap = $urandom_range(1, 20);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {payload, key};
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(predict_transaction(act, key, payload));
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_order(input bit largest);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= largest;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        largest_first = largest;
        order_writes++;
    endtask

    function automatic logic [15:0] pick_key(input int mode);
        case (mode)
            1: return 16'($urandom_range(0, 7));
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h7FFF;
                    3: return 16'h8000;
                    default: return 16'($urandom_range(0, 65535));
                endcase
            end
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [1:0] pick_action(input int insert_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            return bhpq_pkg::ACT_INSERT;
        r = $urandom_range(0, 99);
        if (r < 65)
            return bhpq_pkg::ACT_POP;
        if (r < 95)
            return bhpq_pkg::ACT_PEEK;
        return ACT_UNUSED;
    endfunction

    task automatic test_empty_heap();
        write_order(1'b0);
        send_item(bhpq_pkg::ACT_PEEK, 16'h0000, 8'h00);
        send_item(bhpq_pkg::ACT_POP, 16'hFFFF, 8'hFF);
        send_item(ACT_UNUSED, 16'hFFFF, 8'hFF);
        send_item(ACT_UNUSED, 16'h0000, 8'h00);
    endtask

    task automatic test_min_order();
        send_item(bhpq_pkg::ACT_INSERT, 16'h1234, 8'h01);
        send_item(bhpq_pkg::ACT_INSERT, 16'h0000, 8'h00);
        send_item(bhpq_pkg::ACT_INSERT, 16'hFFFF, 8'hFF);
        send_item(bhpq_pkg::ACT_INSERT, 16'h0000, 8'hAA);   // tie with the root
        send_item(bhpq_pkg::ACT_INSERT, 16'h8000, 8'h55);
        send_item(bhpq_pkg::ACT_PEEK, 16'h0000, 8'h00);
        send_item(ACT_UNUSED, 16'h5A5A, 8'h3C);
        repeat (5) send_item(bhpq_pkg::ACT_POP, 16'h0000, 8'h00);
        send_item(bhpq_pkg::ACT_POP, 16'h0000, 8'h00);
    endtask

    task automatic test_max_order();
        wait_drained();
        write_order(1'b1);
        send_item(bhpq_pkg::ACT_INSERT, 16'h0001, 8'h10);
        send_item(bhpq_pkg::ACT_INSERT, 16'hFFFF, 8'h20);
        send_item(bhpq_pkg::ACT_INSERT, 16'hFFFF, 8'h30);   // an equal key does not climb past the earlier one
        send_item(bhpq_pkg::ACT_INSERT, 16'h0000, 8'h40);
        send_item(bhpq_pkg::ACT_PEEK, 16'h0000, 8'h00);
        repeat (4) send_item(bhpq_pkg::ACT_POP, 16'h0000, 8'h00);
    endtask

    task automatic test_full_heap();
        int i;
        wait_drained();
        write_order(1'($urandom_range(0, 1)));
        for (i = 0; i < HEAP_SLOTS + 3; i++)
            send_item(bhpq_pkg::ACT_INSERT, pick_key(i % 3), 8'($urandom_range(0, 255)));
        send_item(bhpq_pkg::ACT_PEEK, 16'h0000, 8'h00);
        for (i = 0; i < HEAP_SLOTS + 2; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(bhpq_pkg::ACT_PEEK, pick_key(0), 8'($urandom_range(0, 255)));
            send_item(bhpq_pkg::ACT_POP, pick_key(0), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_mix();
        int phase;
        int i;
        int insert_pct;
        int key_mode;
        logic [1:0] act;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            if (phase < 2)
                write_order(phase[0]);
            else
                write_order(1'($urandom_range(0, 1)));
            case ($urandom_range(0, 3))
                0: insert_pct = 30;
                1: insert_pct = 50;
                2: insert_pct = 65;
                default: insert_pct = 90;
            endcase
            key_mode = $urandom_range(0, 2);
            sender_gaps = (phase % 3) != 1;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                act = pick_action(insert_pct);
                send_item(act, pick_key(key_mode), 8'($urandom_range(0, 255)));
            end
        end
        sender_gaps = 1'b1;
    endtask

    // result checking and receiver stalls
    int   rx_mode = 0;
    int   rx_mode_left = 0;
    int   rx_hold_left = 0;
    logic rx_level = 1'b1;
    heap_result_t got;
    heap_result_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.ok      = m_tuser[0];
                got.key     = m_tdata[15:0];
                got.payload = m_tdata[23:16];
                got.count   = m_tdata[30:24];
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: ok %0d key %h payload %h count %0d",
                                 got.ok, got.key, got.payload, got.count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.ok !== want.ok || got.key !== want.key ||
                        got.payload !== want.payload || got.count !== want.count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at %0t: expected ok %0d key %h payload %h ",
                                      "count %0d, got ok %0d key %h payload %h count %0d"},
                                     $time, want.ok, want.key, want.payload, want.count,
                                     got.ok, got.key, got.payload, got.count);
                    end
                end
            end
        end
        if (rx_mode_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(50, 300);
        end
        else
            rx_mode_left--;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default:
            begin
                if (rx_hold_left == 0)
                begin
                    rx_level = ~rx_level;
                    rx_hold_left = $urandom_range(1, 30);
                end
                else
                    rx_hold_left--;
                m_tready <= rx_level;
            end
        endcase
    end

    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_heap();
        test_min_order();
        test_max_order();
        test_full_heap();
        test_random_mix();
        wait_drained();
        repeat (60) @(posedge clk);
        $display("covered %0d results: %0d inserts, %0d pops, %0d peeks, %0d refused",
                 results_checked, inserts_done, pops_done, peeks_done, refused);
        $display("inserts into a full heap %0d, deepest heap %0d, order writes %0d, mismatches %0d",
                 full_refusals, deepest_count, order_writes, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== binary_heap_priority_queue.f =====
sv/bhpq_pkg.sv
sv/bhpq_mem.sv
sv/bhpq_seq.sv
sv/binary_heap_priority_queue.sv
verif/tb_binary_heap_priority_queue.sv
